// ===== rtl/ostms_pkg.sv =====
// shared types and constants for the object slot table
`default_nettype none
package ostms_pkg;

  localparam int WORD_BITS = 64;
  localparam int FREED_W   = 42;
  localparam int COUNT_W   = 11;

  // operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_MARK   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_SWEEP  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE = 2'd2;
  localparam logic [1:0] ST_ZERO     = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  slot;
    logic [63:0] obj_addr;
    logic [31:0] size_bytes;
    logic [15:0] type_id;
    logic        generation;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [9:0]         slot_out;
    logic [63:0]        addr_out;
    logic [31:0]        size_out;
    logic [15:0]        type_out;
    logic               generation_out;
    logic               marked_out;
    logic [FREED_W-1:0] freed_bytes;
    logic [COUNT_W-1:0] live_count;
    logic [COUNT_W-1:0] peak_count;
  } out_t;

  // record word: address, size and mark bit kept together
  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] size;
    logic        mark;
  } rec_t;

  // type and generation, written only by insert
  typedef struct packed {
    logic [15:0] type_id;
    logic        generation;
  } tg_t;

endpackage
`default_nettype wire

// ===== rtl/object_slot_table_mark_sweep.sv =====
// Object slot table: records in ram, free bitmap in 64-bit words, one sequencer.
// Remove, lookup and mark read the slot's record and then act on it; insert scans free-map words
// in order until one has a free bit, else reports full; clear-marks and sweep visit every slot in turn;
// a rejected zero address or out-of-range slot and unused codes go straight to the result.
// One request at a time; the next is taken while the previous result waits.
// After reset a clearing pass over every slot empties the table; no request is
// taken meanwhile.
`default_nettype none
module object_slot_table_mark_sweep #(
  parameter int SLOTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ostms_pkg::in_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ostms_pkg::out_t        out_data
);
  import ostms_pkg::*;

  localparam int SW        = $clog2(SLOTS);
  localparam int MAP_WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int MW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(SLOTS + 1);
  localparam int BW        = $clog2(WORD_BITS);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_SCAN_RD = 4'd3;
  localparam logic [3:0] S_SCAN_CK = 4'd4;
  localparam logic [3:0] S_SLOT_RD = 4'd5;
  localparam logic [3:0] S_SLOT_CK = 4'd6;
  localparam logic [3:0] S_CM_RD   = 4'd7;
  localparam logic [3:0] S_CM_WR   = 4'd8;
  localparam logic [3:0] S_SW_RD   = 4'd9;
  localparam logic [3:0] S_SW_CK   = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]           state;
  logic [SW:0]          idx;
  in_t                  req;
  logic [CW-1:0]        live;
  logic [CW-1:0]        peak;
  logic [FREED_W-1:0]   freed;
  logic [WORD_BITS-1:0] acc;
  out_t                 res;
  out_t                 res_next;
  out_t                 out_word;
  logic                 out_load;

  // ram ports
  logic                 rec_we, tg_we, fm_we;
  logic [SW-1:0]        rec_addr;
  logic [MW-1:0]        fm_addr;
  rec_t                 rec_wd, rec_rd;
  tg_t                  tg_wd, tg_rd;
  logic [WORD_BITS-1:0] fm_wd, fm_rd;

  logic                 ffs_found;
  logic [BW-1:0]        ffs_pos;

  logic [SW-1:0]        req_slot;
  logic                 slot_ok;
  logic [SW-1:0]        idx_slot;
  logic [MW-1:0]        idx_word;
  logic [SW-1:0]        new_slot;
  logic [WORD_BITS-1:0] init_word;
  logic                 rec_live;
  logic                 sw_free;
  logic [WORD_BITS-1:0] acc_upd;

  assign req_slot = SW'(req.slot);
  assign slot_ok  = 32'(req.slot) < SLOTS;
  assign idx_slot = idx[SW-1:0];
  assign idx_word = MW'(idx >> BW);
  assign new_slot = SW'((32'(idx[MW-1:0]) << BW) | 32'(ffs_pos));
  assign rec_live = rec_rd.addr != '0;
  assign sw_free  = !(rec_live && rec_rd.mark);

  // free bits of one word at reset: only slots inside the table
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      init_word[b] = (32'(idx) * WORD_BITS + b) < SLOTS;
    end
  end

  // sweep builds each free-map word bit by bit
  always_comb begin
    acc_upd = acc;
    acc_upd[idx[BW-1:0]] = sw_free;
  end

  ostms_ram #(.WIDTH($bits(rec_t)), .DEPTH(SLOTS)) u_rec (
    .clk(clk), .we(rec_we), .addr(rec_addr), .wdata(rec_wd), .rdata(rec_rd)
  );

  ostms_ram #(.WIDTH($bits(tg_t)), .DEPTH(SLOTS)) u_tg (
    .clk(clk), .we(tg_we), .addr(rec_addr), .wdata(tg_wd), .rdata(tg_rd)
  );

  ostms_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_fmap (
    .clk(clk), .we(fm_we), .addr(fm_addr), .wdata(fm_wd), .rdata(fm_rd)
  );

  ostms_ffs u_ffs (
    .word(fm_rd), .found(ffs_found), .pos(ffs_pos)
  );

  // ram addressing and writes per state
  always_comb begin
    rec_we   = 1'b0;
    tg_we    = 1'b0;
    fm_we    = 1'b0;
    rec_addr = req_slot;
    fm_addr  = MW'(req_slot >> BW);
    rec_wd   = '0;
    tg_wd    = '{type_id: req.type_id, generation: req.generation};
    fm_wd    = fm_rd;
    case (state)
      S_CLR: begin
        rec_addr = idx_slot;
        rec_we   = 1'b1;
        fm_addr  = idx[MW-1:0];
        fm_we    = 32'(idx) < MAP_WORDS;
        fm_wd    = init_word;
      end
      S_SCAN_RD: begin
        fm_addr = idx[MW-1:0];
      end
      S_SCAN_CK: begin
        fm_addr  = idx[MW-1:0];
        rec_addr = new_slot;
        if (ffs_found) begin
          rec_we = 1'b1;
          tg_we  = 1'b1;
          fm_we  = 1'b1;
          rec_wd = '{addr: req.obj_addr, size: req.size_bytes, mark: 1'b0};
          fm_wd[ffs_pos] = 1'b0;
        end
      end
      S_SLOT_CK: begin
        if (rec_live) begin
          if (req.operation == OP_REMOVE) begin
            rec_we = 1'b1;
            fm_we  = 1'b1;
            fm_wd[req_slot[BW-1:0]] = 1'b1;
          end else if (req.operation == OP_MARK) begin
            rec_we = 1'b1;
            rec_wd = rec_rd;
            rec_wd.mark = 1'b1;
          end
        end
      end
      S_CM_RD, S_SW_RD: begin
        rec_addr = idx_slot;
      end
      S_CM_WR: begin
        rec_addr    = idx_slot;
        rec_we      = 1'b1;
        rec_wd      = rec_rd;
        rec_wd.mark = 1'b0;
      end
      S_SW_CK: begin
        rec_addr = idx_slot;
        rec_we   = rec_live && !rec_rd.mark;
        fm_addr  = idx_word;
        fm_we    = (idx[BW-1:0] == {BW{1'b1}}) || (32'(idx) == SLOTS - 1);
        fm_wd    = acc_upd;
      end
      default: begin
      end
    endcase
  end

  // result fields gathered while a request is worked on
  always_comb begin
    res_next = res;
    case (state)
      S_DISP: begin
        res_next = '0;
        case (req.operation)
          OP_INSERT: begin
            if (req.obj_addr == '0) begin
              res_next.status = ST_ZERO;
            end
          end
          OP_REMOVE, OP_LOOKUP, OP_MARK: begin
            res_next.slot_out = req.slot;
            if (!slot_ok) begin
              res_next.status = ST_NOT_LIVE;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN_CK: begin
        if (ffs_found) begin
          res_next.slot_out = 10'(new_slot);
        end else if (32'(idx) == MAP_WORDS - 1) begin
          res_next.status = ST_FULL;
        end
      end
      S_SLOT_CK: begin
        if (!rec_live) begin
          res_next.status = ST_NOT_LIVE;
        end else if (req.operation == OP_LOOKUP) begin
          res_next.addr_out       = rec_rd.addr;
          res_next.size_out       = rec_rd.size;
          res_next.type_out       = tg_rd.type_id;
          res_next.generation_out = tg_rd.generation;
          res_next.marked_out     = rec_rd.mark;
        end
      end
      default: begin
      end
    endcase
  end

  // result word with the running totals
  always_comb begin
    out_word             = res;
    out_word.freed_bytes = freed;
    out_word.live_count  = COUNT_W'(live);
    out_word.peak_count  = COUNT_W'(peak);
  end

  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);
  assign in_stall = state != S_IDLE;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      idx       <= '0;
      live      <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      res <= res_next;
      if (out_load) begin
        out_data  <= out_word;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          idx <= idx + 1'b1;
          if (32'(idx) == SLOTS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          idx   <= '0;
          freed <= '0;
          acc   <= '0;
          case (req.operation)
            OP_INSERT: begin
              if (req.obj_addr == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_SCAN_RD;
              end
            end
            OP_REMOVE, OP_LOOKUP, OP_MARK: begin
              if (slot_ok) begin
                state <= S_SLOT_RD;
              end else begin
                state <= S_DONE;
              end
            end
            OP_CLEAR: begin
              state <= S_CM_RD;
            end
            OP_SWEEP: begin
              state <= S_SW_RD;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CK;
        end
        S_SCAN_CK: begin
          if (ffs_found) begin
            live <= live + 1'b1;
            if (live + 1'b1 > peak) begin
              peak <= live + 1'b1;
            end
            state <= S_DONE;
          end else if (32'(idx) == MAP_WORDS - 1) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_SLOT_RD: begin
          state <= S_SLOT_CK;
        end
        S_SLOT_CK: begin
          state <= S_DONE;
          if (rec_live && req.operation == OP_REMOVE) begin
            live <= live - 1'b1;
          end
        end
        S_CM_RD: begin
          state <= S_CM_WR;
        end
        S_CM_WR: begin
          idx <= idx + 1'b1;
          state <= (32'(idx) == SLOTS - 1) ? S_DONE : S_CM_RD;
        end
        S_SW_RD: begin
          state <= S_SW_CK;
        end
        S_SW_CK: begin
          if (rec_live && !rec_rd.mark) begin
            freed <= freed + FREED_W'(rec_rd.size);
            live  <= live - 1'b1;
          end
          acc <= (idx[BW-1:0] == {BW{1'b1}}) ? '0 : acc_upd;
          idx <= idx + 1'b1;
          state <= (32'(idx) == SLOTS - 1) ? S_DONE : S_SW_RD;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ostms_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module ostms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/ostms_ffs.sv =====
// lowest set bit finder over one free-map word
`default_nettype none
module ostms_ffs (
  input  wire logic [ostms_pkg::WORD_BITS-1:0]          word,
  output logic                                          found,
  output logic [$clog2(ostms_pkg::WORD_BITS)-1:0]       pos
);
  import ostms_pkg::*;

  // scan from the top so the lowest set bit wins
  always_comb begin
    found = |word;
    pos   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (word[b]) begin
        pos = b[$clog2(WORD_BITS)-1:0];
      end
    end
  end
endmodule
`default_nettype wire
